// ===== src/lkv_pkg.sv =====
// shared constants, types and control structs for the lru key-value cache
`timescale 1ns / 1ps
`default_nettype none

package lkv_pkg;

   // store geometry
   localparam int ENTRIES  = 8;
   localparam int KEY_BITS = 32;
   localparam int VAL_BITS = 32;
   localparam int CAP_BITS = 4;
   localparam int RANK_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OCC_W    = $clog2(ENTRIES + 1);

   // capacity after reset
   localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(8);

   typedef logic [KEY_BITS-1:0]        key_type;
   typedef logic signed [VAL_BITS-1:0] value_type;
   typedef logic [RANK_W-1:0]          rank_type;
   typedef logic [OCC_W-1:0]           occ_type;
   typedef logic [CAP_BITS-1:0]        cap_type;
   typedef logic [ENTRIES-1:0]         slot_vec_type;

   // transaction command codes
   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_LOOKUP = 1'b1
   } cmd_type;

   // per-slot update controls from the selection logic
   typedef struct packed {
      logic      load;       // take new key and value as most recent
      logic      set_value;  // overwrite value only
      logic      promote;    // make this slot most recent
      logic      age_all;    // every valid slot gets one step older
      logic      age_below;  // valid slots younger than limit get older
      rank_type  limit;
      key_type   key;
      value_type value;
   } slot_ctl_type;

   // per-slot status to the selection logic
   typedef struct packed {
      logic      valid;
      logic      match;
      rank_type  rank;
      key_type   key;
      value_type value;
   } slot_stat_type;

endpackage

`default_nettype wire

// ===== src/lru_key_value_cache.sv =====
// top level of the fully associative lru key-value cache
`timescale 1ns / 1ps
`default_nettype none

// Fully associative key-value cache of up to 8 entries with least-recently-used
// replacement. A transaction is taken on any clock edge where start is high;
// busy is always low, so one transaction per clock is sustained. Each
// transaction yields exactly one result, strobed by rsp_valid for one cycle:
// the request is registered, then the tag compare, victim and free-slot
// search and rank update all settle combinationally against the slot array and
// land in the result register together with the slot write. The receiver
// cannot stall; results must be taken when strobed. The user must write
// capacity (csr_write_data, 0 means 1, above 8 means 8) only while no
// transaction is in flight; the block itself does not enforce this.
module lru_key_value_cache
   import lkv_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic                req_command,
   input  wire logic [KEY_BITS-1:0] req_key,
   input  wire logic signed [VAL_BITS-1:0] req_value,
   input  wire logic                csr_write_enable,
   input  wire logic [CAP_BITS-1:0] csr_write_data,
   output logic                     rsp_valid,
   output logic                     rsp_hit,
   output logic signed [VAL_BITS-1:0] rsp_read_value,
   output logic                     rsp_evicted,
   output logic [KEY_BITS-1:0]      rsp_evicted_key,
   output logic                     rsp_recent_valid,
   output logic [KEY_BITS-1:0]      rsp_recent_key
);

   // request register
   logic      req_pending_ff;
   cmd_type   req_cmd_ff;
   key_type   req_key_ff;
   value_type req_value_ff;

   // configuration and occupancy
   cap_type capacity_ff;
   occ_type occupancy_ff;
   occ_type occupancy_in;

   // result register
   logic      rsp_valid_ff;
   logic      rsp_hit_ff;
   logic      rsp_hit_in;
   value_type rsp_read_value_ff;
   value_type rsp_read_value_in;
   logic      rsp_evicted_ff;
   logic      rsp_evicted_in;
   key_type   rsp_evicted_key_ff;
   key_type   rsp_evicted_key_in;
   logic      rsp_recent_valid_ff;
   logic      rsp_recent_valid_in;
   key_type   rsp_recent_key_ff;
   key_type   rsp_recent_key_in;

   // slot array
   slot_ctl_type  slot_ctl  [ENTRIES];
   slot_stat_type slot_stat [ENTRIES];

   // selection
   slot_vec_type match_vec;
   slot_vec_type found_vec;
   slot_vec_type victim_vec;
   slot_vec_type free_vec;
   slot_vec_type target_vec;
   slot_vec_type valid_vec;
   slot_vec_type newest_vec;
   rank_type     found_rank;
   value_type    found_value;
   key_type      victim_key;
   key_type      newest_key;
   occ_type      eff_cap;
   occ_type      occ_last;
   logic         is_lookup;
   logic         hit;
   logic         full;
   logic         ins_new;
   logic         found_taken;
   logic         victim_taken;
   logic         free_taken;

   assign busy = 1'b0;

   // request capture
   always_ff @(posedge clock) begin
      if (reset) begin
         req_pending_ff <= 1'b0;
      end else begin
         req_pending_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_cmd_ff   <= cmd_type'(req_command);
         req_key_ff   <= req_key;
         req_value_ff <= req_value;
      end
   end

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_write_enable) begin
         capacity_ff <= csr_write_data;
      end
   end

   // effective capacity: zero acts as one, clipped to the store size
   always_comb begin
      if (capacity_ff == '0) begin
         eff_cap = OCC_W'(1);
      end else if (int'(capacity_ff) > ENTRIES) begin
         eff_cap = OCC_W'(ENTRIES);
      end else begin
         eff_cap = OCC_W'(capacity_ff);
      end
   end

   // slot status vectors
   always_comb begin
      occ_last = occupancy_ff - OCC_W'(1);
      for (int i = 0; i < ENTRIES; i++) begin
         match_vec[i]  = slot_stat[i].match;
         valid_vec[i]  = slot_stat[i].valid;
         newest_vec[i] = slot_stat[i].valid && (slot_stat[i].rank == '0);
      end
   end

   // first hit, oldest entry and first free slot
   always_comb begin
      found_vec    = '0;
      victim_vec   = '0;
      free_vec     = '0;
      found_taken  = 1'b0;
      victim_taken = 1'b0;
      free_taken   = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (match_vec[i] && !found_taken) begin
            found_vec[i] = 1'b1;
            found_taken  = 1'b1;
         end
         if (valid_vec[i] && (slot_stat[i].rank == RANK_W'(occ_last)) && !victim_taken) begin
            victim_vec[i] = 1'b1;
            victim_taken  = 1'b1;
         end
         if (!valid_vec[i] && !free_taken) begin
            free_vec[i] = 1'b1;
            free_taken  = 1'b1;
         end
      end
   end

   // one-hot read muxes
   always_comb begin
      found_rank  = '0;
      found_value = '0;
      victim_key  = '0;
      newest_key  = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (found_vec[i]) begin
            found_rank  = found_rank | slot_stat[i].rank;
            found_value = found_value | slot_stat[i].value;
         end
         if (victim_vec[i]) begin
            victim_key = victim_key | slot_stat[i].key;
         end
         if (newest_vec[i]) begin
            newest_key = newest_key | slot_stat[i].key;
         end
      end
   end

   // transaction decode
   always_comb begin
      is_lookup  = (req_cmd_ff == CMD_LOOKUP);
      hit        = |match_vec;
      full       = (occupancy_ff >= eff_cap);
      ins_new    = req_pending_ff && !is_lookup && !hit;
      target_vec = full ? victim_vec : free_vec;
   end

   // slot controls
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         slot_ctl[i].load      = ins_new && target_vec[i];
         slot_ctl[i].set_value = req_pending_ff && !is_lookup && found_vec[i];
         slot_ctl[i].promote   = req_pending_ff && is_lookup && found_vec[i];
         slot_ctl[i].age_all   = ins_new;
         slot_ctl[i].age_below = req_pending_ff && is_lookup && hit;
         slot_ctl[i].limit     = found_rank;
         slot_ctl[i].key       = req_key_ff;
         slot_ctl[i].value     = req_value_ff;
      end
   end

   // slot array
   for (genvar g = 0; g < ENTRIES; g++) begin : g_slot
      lkv_slot u_slot (
         .clock      (clock),
         .reset      (reset),
         .lookup_key (req_key_ff),
         .ctl        (slot_ctl[g]),
         .stat       (slot_stat[g])
      );
   end

   // occupancy grows only on a new key with room left
   always_comb begin
      occupancy_in = occupancy_ff;
      if (ins_new && !full) begin
         occupancy_in = occupancy_ff + OCC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occupancy_ff <= '0;
      end else begin
         occupancy_ff <= occupancy_in;
      end
   end

   // result fields
   always_comb begin
      rsp_hit_in          = hit;
      rsp_read_value_in   = (is_lookup && hit) ? found_value : '0;
      rsp_evicted_in      = ins_new && full;
      rsp_evicted_key_in  = (ins_new && full) ? victim_key : '0;
      rsp_recent_valid_in = (occupancy_in != '0);
      if ((is_lookup && hit) || ins_new) begin
         rsp_recent_key_in = req_key_ff;
      end else if (occupancy_ff != '0) begin
         rsp_recent_key_in = newest_key;
      end else begin
         rsp_recent_key_in = '0;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_pending_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff          <= rsp_hit_in;
      rsp_read_value_ff   <= rsp_read_value_in;
      rsp_evicted_ff      <= rsp_evicted_in;
      rsp_evicted_key_ff  <= rsp_evicted_key_in;
      rsp_recent_valid_ff <= rsp_recent_valid_in;
      rsp_recent_key_ff   <= rsp_recent_key_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_read_value   = rsp_read_value_ff;
   assign rsp_evicted      = rsp_evicted_ff;
   assign rsp_evicted_key  = rsp_evicted_key_ff;
   assign rsp_recent_valid = rsp_recent_valid_ff;
   assign rsp_recent_key   = rsp_recent_key_ff;

   // every registered transaction yields a result in the next cycle
   a_rsp_follows_req : assert property (@(posedge clock) disable iff (reset)
      req_pending_ff |=> rsp_valid_ff)
      else $error("result strobe missing after transaction");

   // valid slot count tracks the occupancy counter
   a_occ_matches_valid : assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(occupancy_ff))
      else $error("occupancy out of step with valid slots");

   // a non-empty store has exactly one most recent entry
   a_one_newest : assert property (@(posedge clock) disable iff (reset)
      (occupancy_ff != '0) |-> $onehot(newest_vec))
      else $error("most recent entry not unique");

   // an eviction is never reported together with a hit
   a_evict_not_hit : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_evicted_ff) |-> !rsp_hit_ff)
      else $error("eviction reported on a hit");

endmodule

`default_nettype wire

// ===== src/lkv_slot.sv =====
// one cache slot: key, value, valid bit, recency rank and key compare
`timescale 1ns / 1ps
`default_nettype none

module lkv_slot
   import lkv_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire key_type lookup_key,
   input  wire slot_ctl_type ctl,
   output slot_stat_type stat
);

   key_type   key_ff;
   value_type value_ff;
   logic      valid_ff;
   logic      valid_in;
   rank_type  rank_ff;
   rank_type  rank_in;

   // valid and rank update
   always_comb begin
      valid_in = valid_ff;
      rank_in  = rank_ff;
      if (ctl.load) begin
         valid_in = 1'b1;
         rank_in  = '0;
      end else if (ctl.promote) begin
         rank_in = '0;
      end else if (valid_ff && ctl.age_all) begin
         rank_in = rank_ff + RANK_W'(1);
      end else if (valid_ff && ctl.age_below && (rank_ff < ctl.limit)) begin
         rank_in = rank_ff + RANK_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
      end
   end

   // payload storage, no reset
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         key_ff <= ctl.key;
      end
      if (ctl.load || ctl.set_value) begin
         value_ff <= ctl.value;
      end
   end

   // status out
   always_comb begin
      stat.valid = valid_ff;
      stat.match = valid_ff && (key_ff == lookup_key);
      stat.rank  = rank_ff;
      stat.key   = key_ff;
      stat.value = value_ff;
   end

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// testbench for the lru key-value cache: directed and random transactions checked by a behavioral cache
`timescale 1ns / 1ps

module tb;
   import lkv_pkg::*;

   localparam int CYCLE_LIMIT   = 200_000;
   localparam int SETTLE_CYCLES = 4;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS   = 195;

   typedef enum logic [1:0] {
      STEP_ITEM,
      STEP_CSR,
      STEP_DRAIN
   } step_kind_type;

   typedef struct {
      step_kind_type kind;
      cmd_type       cmd;
      key_type       key;
      value_type     value;
      cap_type       cap;
   } stim_step_type;

   typedef struct packed {
      logic      hit;
      value_type read_value;
      logic      evicted;
      key_type   evicted_key;
      logic      recent_valid;
      key_type   recent_key;
   } cache_result_type;

   // dut ports
   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      start = 1'b0;
   logic      busy;
   logic      req_command = 1'b0;
   key_type   req_key = '0;
   value_type req_value = '0;
   logic      csr_write_enable = 1'b0;
   cap_type   csr_write_data = '0;
   logic      rsp_valid;
   logic      rsp_hit;
   value_type rsp_read_value;
   logic      rsp_evicted;
   key_type   rsp_evicted_key;
   logic      rsp_recent_valid;
   key_type   rsp_recent_key;

   // behavioral copy of the cache contents
   key_type     cached_key   [ENTRIES];
   value_type   cached_value [ENTRIES];
   bit          cached_valid [ENTRIES] = '{default: 1'b0};
   int unsigned cached_rank  [ENTRIES] = '{default: 0};
   int unsigned cached_count = 0;
   int unsigned cached_capacity = CAP_RESET;

   // stimulus and scoreboard state
   stim_step_type    pending_steps[$];
   cache_result_type expected_results[$];
   int               items_accepted = 0;
   int               results_seen = 0;
   int               mismatches = 0;
   int               cycle_count = 0;
   int               burst_left = 0;
   int               gap_left = 0;
   int               quiet_cycles = 0;
   logic             all_drained = 1'b0;

   lru_key_value_cache u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_key          (req_key),
      .req_value        (req_value),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_hit          (rsp_hit),
      .rsp_read_value   (rsp_read_value),
      .rsp_evicted      (rsp_evicted),
      .rsp_evicted_key  (rsp_evicted_key),
      .rsp_recent_valid (rsp_recent_valid),
      .rsp_recent_key   (rsp_recent_key)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // valid entries younger than limit get one step older
   function automatic void age_entries(int unsigned limit);
      for (int i = 0; i < ENTRIES; i++)
         if (cached_valid[i] && cached_rank[i] < limit) cached_rank[i]++;
   endfunction

   // apply one transaction to the behavioral cache and return its result
   function automatic cache_result_type cache_access(cmd_type cmd, key_type key, value_type value);
      cache_result_type res;
      int               found;
      int               slot;
      int unsigned      limit;
      res   = '0;
      found = -1;
      slot  = -1;
      limit = (cached_capacity == 0) ? 1 :
              (cached_capacity > ENTRIES) ? ENTRIES : cached_capacity;
      for (int i = 0; i < ENTRIES; i++)
         if (found < 0 && cached_valid[i] && cached_key[i] == key) found = i;
      if (found >= 0) begin
         res.hit = 1'b1;
         // update keeps recency, lookup promotes
         if (cmd == CMD_INSERT) begin
            cached_value[found] = value;
         end else begin
            res.read_value = cached_value[found];
            age_entries(cached_rank[found]);
            cached_rank[found] = 0;
         end
      end else if (cmd == CMD_INSERT) begin
         // at or over capacity: drop the least recent entry
         if (cached_count >= limit) begin
            for (int i = 0; i < ENTRIES; i++)
               if (slot < 0 && cached_valid[i] && cached_rank[i] == cached_count - 1) slot = i;
            if (slot >= 0) begin
               res.evicted     = 1'b1;
               res.evicted_key = cached_key[slot];
               cached_valid[slot] = 1'b0;
               cached_count--;
            end
         end
         if (slot < 0)
            for (int i = 0; i < ENTRIES; i++)
               if (slot < 0 && !cached_valid[i]) slot = i;
         if (slot >= 0) begin
            age_entries(ENTRIES);
            cached_key[slot]   = key;
            cached_value[slot] = value;
            cached_valid[slot] = 1'b1;
            cached_rank[slot]  = 0;
            cached_count++;
         end
      end
      if (cached_count != 0) begin
         res.recent_valid = 1'b1;
         // descending so the lowest matching slot wins
         for (int i = ENTRIES - 1; i >= 0; i--)
            if (cached_valid[i] && cached_rank[i] == 0) res.recent_key = cached_key[i];
      end
      return res;
   endfunction

   task automatic queue_item(cmd_type cmd, key_type key, value_type value);
      pending_steps.push_back('{kind: STEP_ITEM, cmd: cmd, key: key, value: value, cap: '0});
   endtask

   task automatic queue_drain();
      pending_steps.push_back('{kind: STEP_DRAIN, cmd: CMD_INSERT, key: '0, value: '0, cap: '0});
   endtask

   // capacity writes only go out once the cache is idle
   task automatic queue_capacity(cap_type cap);
      queue_drain();
      pending_steps.push_back('{kind: STEP_CSR, cmd: CMD_INSERT, key: '0, value: '0, cap: cap});
   endtask

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: rsp_%s expected %h actual %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // stimulus, reset and end of run
   initial begin : stimulus
      cmd_type     cmd;
      key_type     key;
      value_type   value;
      cap_type     cap;
      int unsigned pool_size;
      key_type     key_pool[$];

      // empty store, extremes of key and value, hits, misses, update
      queue_item(CMD_LOOKUP, 32'h0000_0000, 32'sh1234_5678);
      queue_item(CMD_INSERT, 32'h0000_0000, value_type'(32'h8000_0000));
      queue_item(CMD_INSERT, 32'hffff_ffff, 32'sh7fff_ffff);
      queue_item(CMD_INSERT, 32'h0000_0001, -32'sd1);
      queue_item(CMD_LOOKUP, 32'hffff_ffff, 32'sh0);
      queue_item(CMD_LOOKUP, 32'h0000_0000, 32'sh0);
      queue_item(CMD_LOOKUP, 32'h0000_0005, 32'sh0);
      queue_item(CMD_INSERT, 32'h0000_0001, 32'sh0);
      // fill the store, then evict
      for (int k = 2; k <= 7; k++) queue_item(CMD_INSERT, key_type'(k), value_type'(k * 3));
      queue_item(CMD_LOOKUP, 32'h0000_0001, 32'sh0);
      // capacity zero acts as one and sits below the occupancy
      queue_capacity(4'd0);
      queue_item(CMD_INSERT, 32'h0000_0008, 32'sh55);
      queue_item(CMD_INSERT, 32'h0000_0009, 32'sh66);
      queue_item(CMD_LOOKUP, 32'h0000_0009, 32'sh0);
      queue_item(CMD_INSERT, 32'h0000_0009, 32'sh77);
      // capacity above the store size saturates
      queue_capacity(4'd15);
      queue_item(CMD_INSERT, 32'ha5a5_a5a5, 32'sh5a5a_5a5a);
      queue_item(CMD_LOOKUP, 32'h5a5a_5a5a, 32'sh0);
      queue_capacity(4'd1);
      queue_item(CMD_INSERT, 32'h0000_000a, 32'sh99);

      // random phases, each with its own capacity and a small key pool
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0:       cap = 4'd1;
            1:       cap = 4'd8;
            2:       cap = 4'd0;
            3:       cap = 4'd15;
            4:       cap = 4'd2;
            default: cap = cap_type'($urandom_range(0, 15));
         endcase
         queue_capacity(cap);
         key_pool.delete();
         pool_size = $urandom_range(2, 12);
         for (int j = 0; j < pool_size; j++) key_pool.push_back(key_type'($urandom));
         key_pool[0] = $urandom_range(0, 1) ? '1 : '0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // sender holds off until every result is back
            if (n == PHASE_ITEMS / 2) queue_drain();
            cmd = ($urandom_range(0, 9) < 4) ? CMD_LOOKUP : CMD_INSERT;
            key = ($urandom_range(0, 6) == 0) ? key_type'($urandom) :
                  key_pool[$urandom_range(0, key_pool.size() - 1)];
            case ($urandom_range(0, 15))
               0:       value = value_type'(32'h8000_0000);
               1:       value = 32'sh7fff_ffff;
               2:       value = '1;
               3:       value = '0;
               default: value = value_type'($urandom);
            endcase
            queue_item(cmd, key, value);
         end
      end
      queue_drain();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      wait (all_drained);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, expected_results.size());
         mismatches++;
      end
      if (mismatches == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

   // driver: bursts of transactions, random gaps, idle phases for capacity writes
   always @(posedge clock) begin : driver
      stim_step_type step;
      logic          next_start;
      logic          next_write;
      next_start = 1'b0;
      next_write = 1'b0;
      if (!reset) begin
         // capacity write and transaction taken at this edge
         if (csr_write_enable) cached_capacity = csr_write_data;
         if (start && !busy) begin
            expected_results.push_back(cache_access(cmd_type'(req_command), req_key, req_value));
            items_accepted++;
         end

         if (start && busy) begin
            next_start = 1'b1;
         end else if (gap_left != 0) begin
            gap_left--;
         end else if (pending_steps.size() != 0) begin
            step = pending_steps[0];
            case (step.kind)
               STEP_ITEM: begin
                  pending_steps.delete(0);
                  next_start = 1'b1;
                  req_command <= step.cmd;
                  req_key     <= step.key;
                  req_value   <= step.value;
                  if (burst_left > 1) begin
                     burst_left--;
                  end else begin
                     burst_left = $urandom_range(1, 24);
                     gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                  end
               end
               STEP_CSR: begin
                  pending_steps.delete(0);
                  next_write = 1'b1;
                  csr_write_data <= step.cap;
               end
               STEP_DRAIN: begin
                  // wait for every result, then SETTLE_CYCLES quiet cycles
                  if (!start && !csr_write_enable && results_seen == items_accepted)
                     quiet_cycles++;
                  else
                     quiet_cycles = 0;
                  if (quiet_cycles >= SETTLE_CYCLES) begin
                     pending_steps.delete(0);
                     quiet_cycles = 0;
                     if (pending_steps.size() == 0) all_drained <= 1'b1;
                  end
               end
               default: pending_steps.delete(0);
            endcase
         end
      end
      start            <= next_start;
      csr_write_enable <= next_write;
   end

   // monitor: every strobed result against the oldest expected result
   always @(posedge clock) begin : monitor
      cache_result_type want;
      if (!reset && rsp_valid !== 1'b0) begin
         if (expected_results.size() == 0) begin
            $display("%0t: result with no transaction outstanding, rsp_recent_key %h",
                     $time, rsp_recent_key);
            mismatches++;
         end else begin
            want = expected_results.pop_front();
            results_seen <= results_seen + 1;
            compare_field("valid", 32'd1, {31'd0, rsp_valid});
            compare_field("hit", {31'd0, want.hit}, {31'd0, rsp_hit});
            compare_field("read_value", want.read_value, rsp_read_value);
            compare_field("evicted", {31'd0, want.evicted}, {31'd0, rsp_evicted});
            compare_field("evicted_key", want.evicted_key, rsp_evicted_key);
            compare_field("recent_valid", {31'd0, want.recent_valid}, {31'd0, rsp_recent_valid});
            compare_field("recent_key", want.recent_key, rsp_recent_key);
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run stopped after %0d cycles", $time, cycle_count);
         $display("tb: FAIL");
         $finish;
      end
   end

endmodule

// ===== filelist.f =====
src/lkv_pkg.sv
src/lkv_slot.sv
src/lru_key_value_cache.sv
bench/tb.sv
